FILE: rtl/orl_pkg.sv
`timescale 1ns / 1ps

package orl_pkg;

  // Default bound on the number of records held.
  localparam int DEFAULT_MAX_ENTRIES = 16;

  // Field widths.
  localparam int ACT_W   = 3;
  localparam int ID_W    = 16;
  localparam int VAL_W   = 16;
  localparam int STAT_W  = 2;
  localparam int OCNT_W  = 5;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 56;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE_ID  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd4;
  localparam logic [ACT_W-1:0] ACT_LIST       = 3'd5;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  // One stored record.
  typedef struct packed {
    logic [VAL_W-1:0] occ;
    logic [VAL_W-1:0] cap;
    logic [ID_W-1:0]  id;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              latch_in;
    logic              push_front;
    logic              push_back;
    logic              cnt_dec;
    logic              cnt_clr;
    logic              idx_inc;
    logic              rd_en;
    logic              rd_next;
    logic              wr_shift;
    logic              out_load;
    logic [STAT_W-1:0] out_status;
    logic              out_use_rec;
    logic              out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             full;
    logic             empty;
    logic             id_match;
    logic             idx_last;
    logic             idx_pre_last;
    logic             out_free;
  } stat_t;

endpackage

FILE: rtl/ordered_record_list.sv
`timescale 1ns / 1ps

// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser: action; tdata: entry_id, room_capacity, room_occupancy
// m_axis    out  tuser: status; tdata: entry_count, out_id, out_capacity,
//                out_occupancy; tlast: last_of_run
//
// Records live in a ring buffer held in a RAM with one write port and one
// registered read port; each step of a walk reads a record, then uses the
// data.
// Push, pop, clear and unknown actions: accept, execute, then load the result.
// Remove by id: search from the front, then shift each later record forward.
// List: each record is read, then loaded into the output register.
// Reset is synchronous; it empties the list and the output register.
// A stalled output holds its word; the block takes no new word until every
// result of the current one has been loaded into the output register.

module ordered_record_list #(
  parameter int MAX_ENTRIES = orl_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // entry_id, room_capacity, room_occupancy
  input  logic [orl_pkg::S_DATA_W-1:0] s_axis_tdata,
  // action
  input  logic [orl_pkg::ACT_W-1:0]    s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // entry_count, out_id, out_capacity, out_occupancy, three zero pad bits
  output logic [orl_pkg::M_DATA_W-1:0] m_axis_tdata,
  // status
  output logic [orl_pkg::STAT_W-1:0]   m_axis_tuser,
  output logic                         m_axis_tlast
);

  localparam int PAD_W = orl_pkg::M_DATA_W - orl_pkg::OCNT_W - orl_pkg::REC_W;

  orl_pkg::cmd_t              cmd;
  orl_pkg::stat_t             stat;
  logic [orl_pkg::OCNT_W-1:0] out_count;
  orl_pkg::rec_t              out_rec;

  orl_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  orl_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_action  (s_axis_tuser),
    .in_data    (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_count  (out_count),
    .out_rec    (out_rec),
    .out_last   (m_axis_tlast)
  );

  // Pack the result word.
  assign m_axis_tdata = {{PAD_W{1'b0}}, out_rec, out_count};

endmodule

FILE: rtl/orl_ram.sv
`timescale 1ns / 1ps

module orl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/orl_ctl.sv
`timescale 1ns / 1ps

module orl_ctl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  orl_pkg::stat_t stat,
  output orl_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SH_RD,
    S_SH_WR,
    S_LIST_RD,
    S_LIST_EMIT,
    S_RESULT
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [orl_pkg::STAT_W-1:0]  res_status;
  logic [orl_pkg::STAT_W-1:0]  res_status_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_next = orl_pkg::ST_OK;
        state_next      = S_RESULT;
        unique case (stat.action)
          orl_pkg::ACT_PUSH_FRONT: begin
            if (stat.full) begin
              res_status_next = orl_pkg::ST_FULL;
            end else begin
              cmd.push_front = 1'b1;
            end
          end
          orl_pkg::ACT_PUSH_BACK: begin
            if (stat.full) begin
              res_status_next = orl_pkg::ST_FULL;
            end else begin
              cmd.push_back = 1'b1;
            end
          end
          orl_pkg::ACT_REMOVE_ID: begin
            if (stat.empty) begin
              res_status_next = orl_pkg::ST_EMPTY;
            end else begin
              state_next = S_SRCH_RD;
            end
          end
          orl_pkg::ACT_POP_BACK: begin
            if (stat.empty) begin
              res_status_next = orl_pkg::ST_EMPTY;
            end else begin
              cmd.cnt_dec = 1'b1;
            end
          end
          orl_pkg::ACT_CLEAR: begin
            cmd.cnt_clr = 1'b1;
          end
          orl_pkg::ACT_LIST: begin
            if (stat.empty) begin
              res_status_next = orl_pkg::ST_EMPTY;
            end else begin
              state_next = S_LIST_RD;
            end
          end
          default: begin
            // Unused action codes give a plain ok result.
          end
        endcase
      end
      S_SRCH_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (stat.id_match) begin
          res_status_next = orl_pkg::ST_OK;
          if (stat.idx_last) begin
            cmd.cnt_dec = 1'b1;
            state_next  = S_RESULT;
          end else begin
            state_next = S_SH_RD;
          end
        end else if (stat.idx_last) begin
          res_status_next = orl_pkg::ST_NOTFOUND;
          state_next      = S_RESULT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SRCH_RD;
        end
      end
      S_SH_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_next = 1'b1;
        state_next  = S_SH_WR;
      end
      S_SH_WR: begin
        // Move the record behind the gap one place toward the front.
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (stat.idx_pre_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_RESULT;
        end else begin
          state_next = S_SH_RD;
        end
      end
      S_LIST_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LIST_EMIT;
      end
      S_LIST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_status  = orl_pkg::ST_OK;
          cmd.out_use_rec = 1'b1;
          cmd.out_last    = stat.idx_last;
          if (stat.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_LIST_RD;
          end
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = res_status;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and pending result status.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= orl_pkg::ST_OK;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

endmodule

FILE: rtl/orl_dp.sv
`timescale 1ns / 1ps

module orl_dp #(
  parameter int MAX_ENTRIES = orl_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  orl_pkg::cmd_t                cmd,
  output orl_pkg::stat_t               stat,
  input  logic [orl_pkg::ACT_W-1:0]    in_action,
  input  logic [orl_pkg::S_DATA_W-1:0] in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [orl_pkg::STAT_W-1:0]   out_status,
  output logic [orl_pkg::OCNT_W-1:0]   out_count,
  output orl_pkg::rec_t                out_rec,
  output logic                         out_last
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(MAX_ENTRIES);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_ENTRIES - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_ENTRIES);

  logic [orl_pkg::ACT_W-1:0] action;
  orl_pkg::rec_t             new_rec;
  logic [AW-1:0]             head;
  logic [CW-1:0]             count;
  logic [AW-1:0]             idx;

  logic [AW-1:0]  head_dec;
  logic [AW-1:0]  rd_log;
  logic [AW-1:0]  wr_log;
  logic [AW:0]    rd_sum;
  logic [AW:0]    wr_sum;
  logic [AW-1:0]  rd_phys;
  logic [AW-1:0]  wr_phys;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  orl_pkg::rec_t  wr_data;
  orl_pkg::rec_t  rd_data;
  logic [CW-1:0]  idx_ext;

  // Latched input word; the item is held until its results are out.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      action  <= in_action;
      new_rec <= orl_pkg::rec_t'(in_data);
    end
  end

  // Ring addressing: logical position plus head, wrapped once.
  assign head_dec = (head == '0) ? LAST_SLOT : head - AW'(1);
  assign rd_log   = cmd.rd_next ? idx + AW'(1) : idx;
  assign wr_log   = cmd.push_back ? count[AW-1:0] : idx;
  assign rd_sum   = {1'b0, head} + {1'b0, rd_log};
  assign wr_sum   = {1'b0, head} + {1'b0, wr_log};
  assign rd_phys  = (rd_sum >= DEPTH_EXT) ? AW'(rd_sum - DEPTH_EXT) : rd_sum[AW-1:0];
  assign wr_phys  = (wr_sum >= DEPTH_EXT) ? AW'(wr_sum - DEPTH_EXT) : wr_sum[AW-1:0];

  // Write port selection.
  assign wr_en   = cmd.push_front | cmd.push_back | cmd.wr_shift;
  assign wr_addr = cmd.push_front ? head_dec : wr_phys;
  assign wr_data = cmd.wr_shift ? rd_data : new_rec;

  orl_ram #(
    .WIDTH (orl_pkg::REC_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_phys),
    .rd_data (rd_data)
  );

  // Head pointer, record count and walk index.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.push_front) begin
        head <= head_dec;
      end
      if (cmd.push_front || cmd.push_back) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end else if (cmd.cnt_clr) begin
        count <= '0;
      end
      if (cmd.latch_in) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + AW'(1);
      end
    end
  end

  // Output register; a new word may load as the held one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      out_count  <= orl_pkg::OCNT_W'(count);
      out_rec    <= cmd.out_use_rec ? rd_data : '0;
      out_last   <= cmd.out_last;
    end
  end

  // Status toward the controller.
  assign idx_ext           = CW'(idx);
  assign stat.action       = action;
  assign stat.full         = (count == FULL_CNT);
  assign stat.empty        = (count == '0);
  assign stat.id_match     = (rd_data.id == new_rec.id);
  assign stat.idx_last     = (idx_ext + CW'(1) == count);
  assign stat.idx_pre_last = (idx_ext + CW'(2) == count);
  assign stat.out_free     = !out_valid || out_ready;

endmodule

FILE: rtl/orl_checker.sv
`timescale 1ns / 1ps

module orl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [orl_pkg::S_DATA_W-1:0] s_axis_tdata,
  input logic [orl_pkg::ACT_W-1:0]    s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [orl_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic [orl_pkg::STAT_W-1:0]   m_axis_tuser,
  input logic                         m_axis_tlast
);

  // A word is worked on alone: the input closes right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still ready after accepting a word");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Every result other than ok is a single closing word with no record.
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != orl_pkg::ST_OK) |->
      m_axis_tlast && (m_axis_tdata[orl_pkg::M_DATA_W-1:orl_pkg::OCNT_W] == '0))
    else $error("error result carries record data or is not last");

  // While a listing is still running, no new word is taken.
  a_list_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready in the middle of a listing");

endmodule

bind ordered_record_list orl_checker u_orl_checker (.*);

FILE: dv/ordered_record_list_tb.sv
`timescale 1ns / 1ps

module ordered_record_list_tb;
  import orl_pkg::*;

  // Bound of the list as built with the default parameter.
  localparam int DEPTH = DEFAULT_MAX_ENTRIES;

  // Action codes that the block has no name for; they must be ignored.
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  // Bit offsets of the result fields inside m_axis_tdata.
  localparam int CNT_LSB = 0;
  localparam int ID_LSB  = CNT_LSB + OCNT_W;
  localparam int CAP_LSB = ID_LSB + ID_W;
  localparam int OCC_LSB = CAP_LSB + VAL_W;

  localparam int TOTAL_ITEMS  = 370;
  localparam int CALM_ITEMS   = 60;
  localparam int DRAIN_CYCLES = 120;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SHOW_LIMIT   = 10;

  // One result word as the block should present it.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OCNT_W-1:0] count;
    logic [ID_W-1:0]   id;
    logic [VAL_W-1:0]  cap;
    logic [VAL_W-1:0]  occ;
    logic              last;
  } list_result_t;

  // Shadow copy of the record list and the results it still owes.
  class record_list_tracker;
    rec_t         shadow_records[$];
    list_result_t awaited_results[$];
    int           failures = 0;
    int           words_checked = 0;
    int           peak_depth = 0;
    int           action_tally[8];
    int           status_tally[4];

    function void owe(logic [STAT_W-1:0] status, rec_t rec, logic last);
      list_result_t r;
      r.status = status;
      r.count  = OCNT_W'(shadow_records.size());
      r.id     = rec.id;
      r.cap    = rec.cap;
      r.occ    = rec.occ;
      r.last   = last;
      awaited_results.push_back(r);
      status_tally[status]++;
    endfunction

    // Apply one accepted command to the shadow list and queue its results.
    function void note_word(logic [ACT_W-1:0] action, logic [ID_W-1:0] id,
                            logic [VAL_W-1:0] cap, logic [VAL_W-1:0] occ);
      rec_t              rec;
      rec_t              blank;
      logic [STAT_W-1:0] status;
      bit                hit;
      int                n;
      rec.id = id;
      rec.cap = cap;
      rec.occ = occ;
      blank = '0;
      status = ST_OK;
      hit = 1'b0;
      n = shadow_records.size();
      action_tally[action]++;
      if (action == ACT_LIST) begin
        if (n == 0) begin
          owe(ST_EMPTY, blank, 1'b1);
        end else begin
          for (int i = 0; i < n; i++)
            owe(ST_OK, shadow_records[i], i == n - 1);
        end
      end else begin
        case (action)
          ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (n >= DEPTH) status = ST_FULL;
            else if (action == ACT_PUSH_FRONT) shadow_records.push_front(rec);
            else shadow_records.push_back(rec);
          end
          ACT_REMOVE_ID: begin
            if (n == 0) begin
              status = ST_EMPTY;
            end else begin
              // Only the match nearest the front goes.
              for (int i = 0; i < n && !hit; i++) begin
                if (shadow_records[i].id == id) begin
                  shadow_records.delete(i);
                  hit = 1'b1;
                end
              end
              status = hit ? ST_OK : ST_NOTFOUND;
            end
          end
          ACT_POP_BACK: begin
            if (n == 0) status = ST_EMPTY;
            else void'(shadow_records.pop_back());
          end
          ACT_CLEAR: shadow_records.delete();
          default: ;
        endcase
        owe(status, blank, 1'b1);
      end
      if (shadow_records.size() > peak_depth) peak_depth = shadow_records.size();
    endfunction

    function void complain(string what, list_result_t want, list_result_t got);
      failures++;
      if (failures <= SHOW_LIMIT) begin
        $write("%t %s: expected st=%0d cnt=%0d id=%h cap=%h occ=%h last=%b,",
               $realtime, what, want.status, want.count, want.id, want.cap,
               want.occ, want.last);
        $display(" got st=%0d cnt=%0d id=%h cap=%h occ=%h last=%b",
                 got.status, got.count, got.id, got.cap, got.occ, got.last);
      end
    endfunction

    // Compare one accepted result word with the oldest one owed.
    function void check_word(logic [STAT_W-1:0] tuser, logic [M_DATA_W-1:0] tdata,
                             logic tlast);
      list_result_t got;
      list_result_t want;
      got.status = tuser;
      got.count  = tdata[CNT_LSB +: OCNT_W];
      got.id     = tdata[ID_LSB +: ID_W];
      got.cap    = tdata[CAP_LSB +: VAL_W];
      got.occ    = tdata[OCC_LSB +: VAL_W];
      got.last   = tlast;
      words_checked++;
      if (awaited_results.size() == 0) begin
        complain("unexpected result", '0, got);
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.count !== want.count ||
            got.id !== want.id || got.cap !== want.cap ||
            got.occ !== want.occ || got.last !== want.last)
          complain("result mismatch", want, got);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [ACT_W-1:0]    s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]   m_axis_tuser;
  logic                m_axis_tlast;

  record_list_tracker tracker;
  int                 sent = 0;
  int                 stall_left = 0;
  int                 quiet_cycles = 0;
  bit                 sender_gaps = 1'b1;
  bit                 receiver_stalls = 1'b1;
  bit                 calm = 1'b0;

  ordered_record_list #(
    .MAX_ENTRIES(DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk = ~clk;

  // Result side: check each accepted word, then decide on the next stall.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_word(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && receiver_stalls && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: give up when neither side has moved a word for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VAL_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Small ids half the time so that duplicates and hits are common.
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 1) == 0) return ID_W'($urandom_range(0, 7));
    return pick_value();
  endfunction

  function automatic logic [ACT_W-1:0] pick_action();
    int w;
    w = $urandom_range(0, 99);
    if (w < 18) return ACT_PUSH_FRONT;
    if (w < 36) return ACT_PUSH_BACK;
    if (w < 56) return ACT_REMOVE_ID;
    if (w < 66) return ACT_POP_BACK;
    if (w < 80) return ACT_LIST;
    if (w < 85) return ACT_CLEAR;
    if (w < 90) return ACT_SPARE_LO;
    if (w < 95) return ACT_SPARE_HI;
    return ACT_PUSH_BACK;
  endfunction

  // Present one command word, with an optional gap ahead of it.
  task automatic send_word(input logic [ACT_W-1:0] action, input logic [ID_W-1:0] id,
                           input logic [VAL_W-1:0] cap, input logic [VAL_W-1:0] occ);
    int gap;
    if (!calm && sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= {occ, cap, id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.note_word(action, id, cap, occ);
    sent++;
  endtask

  // Random command; removes mostly aim at an id that is present.
  task automatic issue(input logic [ACT_W-1:0] action);
    logic [ID_W-1:0] id;
    int              n;
    n = tracker.shadow_records.size();
    if (action == ACT_REMOVE_ID && n > 0 && $urandom_range(0, 9) < 7)
      id = tracker.shadow_records[$urandom_range(0, n - 1)].id;
    else
      id = pick_id();
    send_word(action, id, pick_value(), pick_value());
  endtask

  initial begin
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty-list cases and the ignored action codes.
    send_word(ACT_LIST, 16'h0000, 16'h0000, 16'h0000);
    send_word(ACT_POP_BACK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(ACT_REMOVE_ID, 16'h0000, 16'h0000, 16'h0000);
    send_word(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    send_word(ACT_SPARE_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(ACT_SPARE_HI, 16'hA5A5, 16'h5A5A, 16'hFFFF);
    // Extreme field values, a duplicate id and both ends of the list.
    send_word(ACT_PUSH_FRONT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(ACT_PUSH_BACK, 16'h0000, 16'h0000, 16'h0000);
    send_word(ACT_PUSH_BACK, 16'hFFFF, 16'h1234, 16'h5678);
    send_word(ACT_PUSH_FRONT, 16'h8001, 16'hAAAA, 16'h5555);
    send_word(ACT_LIST, 16'h0000, 16'h0000, 16'h0000);
    // The duplicate nearest the front goes; a missing id changes nothing.
    send_word(ACT_REMOVE_ID, 16'hFFFF, 16'h0000, 16'h0000);
    send_word(ACT_REMOVE_ID, 16'h4242, 16'h0000, 16'h0000);
    send_word(ACT_LIST, 16'h0000, 16'h0000, 16'h0000);
    send_word(ACT_POP_BACK, 16'h0000, 16'h0000, 16'h0000);
    send_word(ACT_SPARE_LO, 16'h0001, 16'h0002, 16'h0003);
    send_word(ACT_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(ACT_LIST, 16'h0000, 16'h0000, 16'h0000);

    // Random episodes: fill to the bound, drain to empty, or mixed traffic.
    while (sent < TOTAL_ITEMS) begin
      calm = sent >= TOTAL_ITEMS - CALM_ITEMS;
      sender_gaps = $urandom_range(0, 2) != 0;
      receiver_stalls = $urandom_range(0, 2) != 0;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          while (tracker.shadow_records.size() < DEPTH)
            issue($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK);
          repeat ($urandom_range(1, 3))
            issue($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK);
          issue(ACT_LIST);
        end
        5, 6, 7, 8: begin
          while (tracker.shadow_records.size() > 0)
            issue($urandom_range(0, 9) < 7 ? ACT_REMOVE_ID : ACT_POP_BACK);
          issue($urandom_range(0, 1) ? ACT_REMOVE_ID : ACT_POP_BACK);
          issue(ACT_LIST);
        end
        default: begin
          repeat ($urandom_range(8, 20)) issue(pick_action());
        end
      endcase
    end
    s_axis_tvalid <= 1'b0;

    // Let the last results drain, then allow for any stray words.
    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $write("Covered %0d commands: push front %0d, push back %0d, remove %0d, ",
           sent, tracker.action_tally[ACT_PUSH_FRONT],
           tracker.action_tally[ACT_PUSH_BACK], tracker.action_tally[ACT_REMOVE_ID]);
    $display("pop %0d, clear %0d, list %0d, spare codes %0d.",
             tracker.action_tally[ACT_POP_BACK], tracker.action_tally[ACT_CLEAR],
             tracker.action_tally[ACT_LIST],
             tracker.action_tally[ACT_SPARE_LO] + tracker.action_tally[ACT_SPARE_HI]);
    $write("Checked %0d result words; empty %0d, not found %0d, full refusals %0d; ",
           tracker.words_checked, tracker.status_tally[ST_EMPTY],
           tracker.status_tally[ST_NOTFOUND], tracker.status_tally[ST_FULL]);
    $display("peak depth %0d of %0d; %0d failures.",
             tracker.peak_depth, DEPTH, tracker.failures);
    if (tracker.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
